[sv/ssba_pkg.sv]
// ----------------------------------------------------------------------------
// Swap slot allocator package
// Shared types, constants and state codes for the first-fit swap slot
// allocator: request and response records, queue commands and sizes.
// ----------------------------------------------------------------------------
package ssba_pkg;

   // Sizes of the slot space and the occupancy bitmap.
   localparam int MAX_SLOTS    = 1024;
   localparam int SLOT_SECTORS = 8;
   localparam int WORD_W       = 32;
   localparam int WORDS        = MAX_SLOTS / WORD_W;
   localparam int WBIT_W       = $clog2(WORD_W);
   localparam int WADDR_W      = $clog2(WORDS);

   // Field widths.
   localparam int ACTION_W = 2;
   localparam int SLOT_W   = 10;
   localparam int STATUS_W = 2;
   localparam int SECTOR_W = 13;
   localparam int CNT_W    = 11;
   localparam int OFF_W    = $clog2(SLOT_SECTORS + 1);

   // Depth of the command queue between front and back.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Request action codes.
   localparam logic [ACTION_W-1:0] ACT_SWAP_OUT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SWAP_IN  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE  = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_HELD = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

   // Slot count after reset.
   localparam logic [CNT_W-1:0] SLOT_LIMIT_RST = 11'd1024;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SLOT_W-1:0]   slot;
      logic                slot_held;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
      logic [SECTOR_W-1:0] sector;
      logic                sector_valid;
      logic                is_write;
      logic                last;
   } rsp_type;

   // Work items handed from the front to the back.
   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_READ,
      CMD_FREE,
      CMD_REPORT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EMIT,
      BK_CLEAR,
      BK_REPORT
   } back_state_type;

endpackage

[sv/ssba_front.sv]
// ----------------------------------------------------------------------------
// Swap slot allocator front end
// Accepts requests, sorts them into back-end commands and settles the
// held-slot and range checks of swap in and release.
// ----------------------------------------------------------------------------
module ssba_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  ssba_pkg::req_type         req_data,
   input  logic [ssba_pkg::CNT_W-1:0] act_cnt,
   output logic                      push,
   output ssba_pkg::cmd_type         push_cmd,
   input  logic                      q_full
);

   logic              fr_vld_ff, fr_vld_in;
   ssba_pkg::cmd_type fr_cmd_ff, fr_cmd_in;
   ssba_pkg::cmd_type cls_cmd;
   logic              cls_keep;
   logic              accept;
   logic              in_range;

   // The holding register moves into the queue whenever the queue has room.
   assign push     = fr_vld_ff && !q_full;
   assign push_cmd = fr_cmd_ff;
   assign busy     = fr_vld_ff && q_full;
   assign accept   = start && !busy;

   // Classify the request.
   always_comb begin
      in_range       = ssba_pkg::CNT_W'(req_data.slot) < act_cnt;
      cls_keep       = 1'b1;
      cls_cmd.kind   = ssba_pkg::CMD_REPORT;
      cls_cmd.status = ssba_pkg::ST_OK;
      cls_cmd.slot   = '0;
      case (req_data.action)
         ssba_pkg::ACT_SWAP_OUT: begin
            cls_cmd.kind = ssba_pkg::CMD_ALLOC;
         end
         ssba_pkg::ACT_SWAP_IN: begin
            if (!req_data.slot_held) begin
               cls_cmd.status = ssba_pkg::ST_NOT_HELD;
            end else if (!in_range) begin
               cls_cmd.status = ssba_pkg::ST_RANGE;
               cls_cmd.slot   = req_data.slot;
            end else begin
               cls_cmd.kind = ssba_pkg::CMD_READ;
               cls_cmd.slot = req_data.slot;
            end
         end
         ssba_pkg::ACT_RELEASE: begin
            if (!req_data.slot_held) begin
               cls_cmd.status = ssba_pkg::ST_OK;
            end else if (!in_range) begin
               cls_cmd.status = ssba_pkg::ST_RANGE;
               cls_cmd.slot   = req_data.slot;
            end else begin
               cls_cmd.kind = ssba_pkg::CMD_FREE;
               cls_cmd.slot = req_data.slot;
            end
         end
         default: begin
            // The unused action code is dropped without a response.
            cls_keep = 1'b0;
         end
      endcase
   end

   // Next value of the holding register.
   always_comb begin
      fr_vld_in = fr_vld_ff && !push;
      fr_cmd_in = fr_cmd_ff;
      if (accept) begin
         fr_vld_in = cls_keep;
         fr_cmd_in = cls_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_vld_ff <= 1'b0;
      end else begin
         fr_vld_ff <= fr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      fr_cmd_ff <= fr_cmd_in;
   end

endmodule

[sv/ssba_cmd_queue.sv]
// ----------------------------------------------------------------------------
// Swap slot allocator command queue
// Short first-in first-out queue of commands between the front end and the
// back end.
// ----------------------------------------------------------------------------
module ssba_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ssba_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              q_vld,
   output ssba_pkg::cmd_type q_cmd
);

   ssba_pkg::cmd_type                   slot_q_ff [ssba_pkg::CMDQ_DEPTH];
   logic [ssba_pkg::CMDQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ssba_pkg::CMDQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ssba_pkg::CMDQ_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                                do_push, do_pop;

   assign full    = cnt_ff == ssba_pkg::CMDQ_CNT_W'(ssba_pkg::CMDQ_DEPTH);
   assign q_vld   = cnt_ff != '0;
   assign q_cmd   = slot_q_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_vld;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ssba_pkg::CMDQ_PTR_W'(ssba_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ssba_pkg::CMDQ_PTR_W'(ssba_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/ssba_back.sv]
// ----------------------------------------------------------------------------
// Swap slot allocator back end
// Owns the occupancy bitmap, scans it word by word for the lowest free
// slot, and issues the sector transfers and single-line responses.
// ----------------------------------------------------------------------------
module ssba_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ssba_pkg::CNT_W-1:0] act_cnt,
   input  logic                       q_vld,
   input  ssba_pkg::cmd_type          q_cmd,
   output logic                       pop,
   output logic                       rsp_valid,
   output ssba_pkg::rsp_type          rsp_data
);

   // Bitmap memory, one word per group of slots, plus a written flag per word.
   logic [ssba_pkg::WORD_W-1:0]  bmp_mem [ssba_pkg::WORDS];
   logic [ssba_pkg::WORDS-1:0]   word_vld_ff;
   logic [ssba_pkg::WORD_W-1:0]  rd_data_ff;
   logic                         rd_vld_ff;
   logic                         rd_en;
   logic [ssba_pkg::WADDR_W-1:0] rd_addr;
   logic                         wr_en;
   logic [ssba_pkg::WADDR_W-1:0] wr_addr;
   logic [ssba_pkg::WORD_W-1:0]  wr_data;
   logic [ssba_pkg::WORD_W-1:0]  word_eff;

   ssba_pkg::back_state_type     state_ff, state_in;
   ssba_pkg::cmd_type            cur_ff, cur_in;
   logic [ssba_pkg::WADDR_W-1:0] w_ff, w_in;
   logic [ssba_pkg::OFF_W-1:0]   off_ff, off_in;
   logic                         rsp_vld_ff, rsp_vld_in;
   ssba_pkg::rsp_type            rsp_ff, rsp_in;

   logic [ssba_pkg::WORD_W-1:0]  free_mask;
   logic                         free_any;
   logic [ssba_pkg::WBIT_W-1:0]  free_bit;
   logic                         more_words;
   logic [ssba_pkg::WADDR_W-1:0] cur_word;
   logic [ssba_pkg::WBIT_W-1:0]  cur_bit;
   logic                         off_last;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // A word never written reads as all free.
   assign word_eff = rd_vld_ff ? rd_data_ff : '0;
   assign cur_word = ssba_pkg::WADDR_W'(cur_ff.slot >> ssba_pkg::WBIT_W);
   assign cur_bit  = cur_ff.slot[ssba_pkg::WBIT_W-1:0];
   assign off_last = off_ff == ssba_pkg::OFF_W'(ssba_pkg::SLOT_SECTORS - 1);

   // Free slots of the scanned word that lie below the active count.
   always_comb begin
      for (int b = 0; b < ssba_pkg::WORD_W; b++) begin
         free_mask[b] = !word_eff[b] &&
                        (ssba_pkg::CNT_W'({w_ff, ssba_pkg::WBIT_W'(b)}) < act_cnt);
      end
   end

   // Lowest free slot of the word.
   always_comb begin
      free_bit = '0;
      for (int b = ssba_pkg::WORD_W - 1; b >= 0; b--) begin
         if (free_mask[b]) begin
            free_bit = ssba_pkg::WBIT_W'(b);
         end
      end
   end

   assign free_any   = |free_mask;
   assign more_words = (ssba_pkg::CNT_W'({1'b0, w_ff} + 1'b1) << ssba_pkg::WBIT_W) < act_cnt;

   // Sequencer: next state, memory accesses and responses.
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      w_in       = w_ff;
      off_in     = off_ff;
      pop        = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = cur_word;
      wr_data    = word_eff;
      rsp_vld_in = 1'b0;
      rsp_in     = '0;
      case (state_ff)
         ssba_pkg::BK_IDLE: begin
            if (q_vld) begin
               pop    = 1'b1;
               cur_in = q_cmd;
               w_in   = '0;
               off_in = '0;
               case (q_cmd.kind)
                  ssba_pkg::CMD_ALLOC: begin
                     if (act_cnt == '0) begin
                        cur_in.status = ssba_pkg::ST_NO_FREE;
                        cur_in.slot   = '0;
                        state_in      = ssba_pkg::BK_REPORT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ssba_pkg::BK_SCAN;
                     end
                  end
                  ssba_pkg::CMD_READ: begin
                     state_in = ssba_pkg::BK_EMIT;
                  end
                  ssba_pkg::CMD_FREE: begin
                     rd_en    = 1'b1;
                     rd_addr  = ssba_pkg::WADDR_W'(q_cmd.slot >> ssba_pkg::WBIT_W);
                     state_in = ssba_pkg::BK_CLEAR;
                  end
                  default: begin
                     state_in = ssba_pkg::BK_REPORT;
                  end
               endcase
            end
         end
         ssba_pkg::BK_SCAN: begin
            // One bitmap word per cycle; the next read is issued alongside.
            if (free_any) begin
               wr_en       = 1'b1;
               wr_addr     = w_ff;
               wr_data     = word_eff | (ssba_pkg::WORD_W'(1) << free_bit);
               cur_in.slot = ssba_pkg::SLOT_W'({w_ff, free_bit});
               state_in    = ssba_pkg::BK_EMIT;
            end else if (more_words) begin
               w_in    = w_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = w_ff + 1'b1;
            end else begin
               cur_in.status = ssba_pkg::ST_NO_FREE;
               cur_in.slot   = '0;
               state_in      = ssba_pkg::BK_REPORT;
            end
         end
         ssba_pkg::BK_EMIT: begin
            // One sector transfer per cycle.
            rsp_vld_in          = 1'b1;
            rsp_in.status       = ssba_pkg::ST_OK;
            rsp_in.slot_index   = cur_ff.slot;
            rsp_in.sector       = ssba_pkg::SECTOR_W'(ssba_pkg::SECTOR_W'(cur_ff.slot) *
                                  ssba_pkg::SECTOR_W'(ssba_pkg::SLOT_SECTORS)) +
                                  ssba_pkg::SECTOR_W'(off_ff);
            rsp_in.sector_valid = 1'b1;
            rsp_in.is_write     = cur_ff.kind == ssba_pkg::CMD_ALLOC;
            rsp_in.last         = off_last;
            off_in              = off_ff + 1'b1;
            if (off_last) begin
               if (cur_ff.kind == ssba_pkg::CMD_READ) begin
                  rd_en    = 1'b1;
                  rd_addr  = cur_word;
                  state_in = ssba_pkg::BK_CLEAR;
               end else begin
                  state_in = ssba_pkg::BK_IDLE;
               end
            end
         end
         ssba_pkg::BK_CLEAR: begin
            // Free the slot; a release reports in the same cycle.
            wr_en   = 1'b1;
            wr_addr = cur_word;
            wr_data = word_eff & ~(ssba_pkg::WORD_W'(1) << cur_bit);
            if (cur_ff.kind == ssba_pkg::CMD_FREE) begin
               rsp_vld_in        = 1'b1;
               rsp_in.status     = ssba_pkg::ST_OK;
               rsp_in.slot_index = cur_ff.slot;
               rsp_in.last       = 1'b1;
            end
            state_in = ssba_pkg::BK_IDLE;
         end
         ssba_pkg::BK_REPORT: begin
            rsp_vld_in        = 1'b1;
            rsp_in.status     = cur_ff.status;
            rsp_in.slot_index = cur_ff.slot;
            rsp_in.last       = 1'b1;
            state_in          = ssba_pkg::BK_IDLE;
         end
         default: begin
            state_in = ssba_pkg::BK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ssba_pkg::BK_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      w_ff   <= w_in;
      off_ff <= off_in;
      rsp_ff <= rsp_in;
   end

   // Written flags: a word reads as free until its first write.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_vld_ff <= '0;
      end else if (wr_en) begin
         word_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Bitmap memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bmp_mem[wr_addr] <= wr_data;
      end
   end

   // Bitmap memory registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= bmp_mem[rd_addr];
         rd_vld_ff  <= word_vld_ff[rd_addr];
      end
   end

endmodule

[sv/swap_slot_bitmap_allocator_top.sv]
// ----------------------------------------------------------------------------
// Swap slot bitmap allocator
// First-fit swap slot allocator: hands out the lowest free slot, streams
// the sector addresses of a slot on swap out and swap in, and frees slots.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                         Transfer
//  request   start, busy, req_data         start high while busy low
//  response  rsp_valid, rsp_data           each response valid for a single cycle, no stall
//  config    csr_we, csr_wdata             csr_we high, no wait
//
// A swap out is dispatched, then scans the bitmap for the lowest free
// slot one 32-slot word at a time (up to 32 words) and streams eight
// sector responses. A swap in streams eight sector responses and then
// frees the slot; a release or an error gets a single response. Requests
// pass a holding register and a two-entry queue, so busy rises only when
// both are full. Reset is synchronous; the bitmap reads as all free right
// after reset. Responses cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  ssba_pkg::req_type          req_data,
   output logic                       rsp_valid,
   output ssba_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic [ssba_pkg::CNT_W-1:0] csr_wdata
);

   logic [ssba_pkg::CNT_W-1:0] slot_limit_ff, slot_limit_in;
   logic [ssba_pkg::CNT_W-1:0] act_cnt;
   logic                       push;
   ssba_pkg::cmd_type          push_cmd;
   logic                       q_full;
   logic                       pop;
   logic                       q_vld;
   ssba_pkg::cmd_type          q_cmd;

   // Slot count register.
   assign slot_limit_in = csr_we ? csr_wdata : slot_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_limit_ff <= ssba_pkg::SLOT_LIMIT_RST;
      end else begin
         slot_limit_ff <= slot_limit_in;
      end
   end

   // Active count is limited to the size of the bitmap.
   assign act_cnt = (slot_limit_ff > ssba_pkg::CNT_W'(ssba_pkg::MAX_SLOTS)) ?
                    ssba_pkg::CNT_W'(ssba_pkg::MAX_SLOTS) : slot_limit_ff;

   ssba_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .act_cnt  (act_cnt),
      .push     (push),
      .push_cmd (push_cmd),
      .q_full   (q_full)
   );

   ssba_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .q_vld    (q_vld),
      .q_cmd    (q_cmd)
   );

   ssba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .act_cnt   (act_cnt),
      .q_vld     (q_vld),
      .q_cmd     (q_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
